[sv/sads_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stick axis deadzone scaler.
// No dependencies.
package sads_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int AXIS_COUNT  = 4;
	localparam int AXIS_BITS   = 2;
	localparam int CAL_SLOTS   = 4;
	localparam int CAL_W       = 3 * SAMPLE_BITS;
	localparam int OUT_W       = 16;
	localparam int SCALE_BITS  = 15;
	localparam int NUM_W       = SAMPLE_BITS + SCALE_BITS;
	localparam int REG_IDX_W   = 3;
	localparam int LATENCY     = NUM_W + 3;

	localparam logic [SAMPLE_BITS-1:0] DZ_RESET  = SAMPLE_BITS'(160);
	localparam logic [CAL_W-1:0]       CAL_RESET = CAL_W'(64'd26850101248);

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEADZONE = 3'd0,
		REG_LX_CAL   = 3'd1,
		REG_LY_CAL   = 3'd2,
		REG_RX_CAL   = 3'd3,
		REG_RY_CAL   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] raw_position;
		logic [AXIS_BITS-1:0]   axis_index;
	} sads_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] scaled_axis;
		logic [AXIS_BITS-1:0]    axis_tag;
	} sads_res_t;

	typedef struct packed {
		logic [AXIS_BITS-1:0] tag;
		logic                 neg;
		logic                 zero;
	} sads_meta_t;

	typedef struct packed {
		sads_meta_t             meta;
		logic [SAMPLE_BITS-1:0] rem;
		logic [SAMPLE_BITS-1:0] den;
		logic [NUM_W-1:0]       word;
	} sads_div_t;

endpackage

[sv/sads_front.sv]
`timescale 1ns / 1ps
// Front end: center offset, dead band, span and divisor, then span * 32767.
// Depends on sads_pkg.
module sads_front import sads_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  sads_req_t              req,
	input  logic [SAMPLE_BITS-1:0] dz,
	input  logic [CAL_W-1:0]       cal,
	output logic                   valid_s2,
	output sads_div_t              div_s2
);

	logic [SAMPLE_BITS-1:0] center, below, above, side, mag, span, rng;
	logic signed [SAMPLE_BITS:0] offset;
	logic [SAMPLE_BITS:0] mag_full;
	logic pos, dead, axis_ok;

	logic                   valid_s1;
	sads_meta_t             meta_s1;
	logic [SAMPLE_BITS-1:0] span_s1;
	logic [SAMPLE_BITS-1:0] rng_s1;

	always_comb begin
		center   = cal[SAMPLE_BITS-1:0];
		below    = cal[2*SAMPLE_BITS-1:SAMPLE_BITS];
		above    = cal[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
		offset   = $signed({1'b0, req.raw_position}) - $signed({1'b0, center});
		pos      = !offset[SAMPLE_BITS] && (offset != '0);
		mag_full = offset[SAMPLE_BITS] ? (~offset + 1'b1) : offset;
		mag      = mag_full[SAMPLE_BITS-1:0];
		dead     = mag < dz;
		side     = pos ? above : below;
		rng      = (side > dz) ? side - dz : SAMPLE_BITS'(1);
		span     = mag - dz;
		axis_ok  = 32'(req.axis_index) < AXIS_COUNT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1.tag  <= req.axis_index;
		meta_s1.neg  <= !pos;
		meta_s1.zero <= dead || !axis_ok;
		span_s1      <= span;
		rng_s1       <= rng;
		div_s2.meta  <= meta_s1;
		div_s2.rem   <= '0;
		div_s2.den   <= rng_s1;
		div_s2.word  <= NUM_W'({span_s1, SCALE_BITS'(0)}) - NUM_W'(span_s1);
	end

endmodule

[sv/sads_cell.sv]
`timescale 1ns / 1ps
// One restoring divider cell: one quotient bit, handed on to the next cell.
// Depends on sads_pkg.
module sads_cell import sads_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  sads_div_t d_in,
	output logic      valid_out,
	output sads_div_t d_out
);

	logic [SAMPLE_BITS:0] trial, diff;
	logic take;

	always_comb begin
		trial = {d_in.rem, d_in.word[NUM_W-1]};
		take  = trial >= {1'b0, d_in.den};
		diff  = trial - {1'b0, d_in.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out.meta <= d_in.meta;
		d_out.den  <= d_in.den;
		d_out.rem  <= take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
		d_out.word <= {d_in.word[NUM_W-2:0], take};
	end

endmodule

[sv/sads_back.sv]
`timescale 1ns / 1ps
// Back end: sign, saturation and dead-band zeroing of the quotient.
// Depends on sads_pkg.
module sads_back import sads_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  sads_div_t d_in,
	output logic      done,
	output sads_res_t result
);

	logic sat;
	logic signed [OUT_W-1:0] low, value;

	always_comb begin
		sat = |d_in.word[NUM_W-1:SCALE_BITS];
		low = d_in.word[OUT_W-1:0];
		if (d_in.meta.zero) begin
			value = '0;
		end else if (sat) begin
			value = d_in.meta.neg ? OUT_MIN : OUT_MAX;
		end else begin
			value = d_in.meta.neg ? -low : low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		result.scaled_axis <= value;
		result.axis_tag    <= d_in.meta.tag;
	end

endmodule

[sv/stick_axis_deadzone_scaler_unit.sv]
`timescale 1ns / 1ps
// Top level of the stick axis deadzone scaler: registers, front end, divider chain, back end.
// Depends on sads_pkg, sads_front, sads_cell, sads_back.

// A request is taken on every cycle that start is high; busy never rises.
// Each request gives one result through two front-end stages, one divider
// cell per quotient bit (27 here) and one output stage, marked by a
// one-cycle done pulse. Results come out in request order at one per cycle;
// the receiver has no way to stall them. Deadzone and calibration are
// sampled when a request is taken, so write them only while no request is
// in flight.
module stick_axis_deadzone_scaler_unit import sads_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sads_req_t            req,
	output logic                 done,
	output sads_res_t            result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CAL_W-1:0]     wr_data
);

	logic [SAMPLE_BITS-1:0] dz_q;
	logic [CAL_W-1:0]       cal_q [CAL_SLOTS];

	logic      chain_valid [NUM_W+1];
	sads_div_t chain_d     [NUM_W+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
			for (int i = 0; i < CAL_SLOTS; i++) begin
				cal_q[i] <= CAL_RESET;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_DEADZONE: dz_q     <= wr_data[SAMPLE_BITS-1:0];
				REG_LX_CAL:   cal_q[0] <= wr_data;
				REG_LY_CAL:   cal_q[1] <= wr_data;
				REG_RX_CAL:   cal_q[2] <= wr_data;
				REG_RY_CAL:   cal_q[3] <= wr_data;
				default:      ;
			endcase
		end
	end

	sads_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !busy),
		.req      (req),
		.dz       (dz_q),
		.cal      (cal_q[req.axis_index]),
		.valid_s2 (chain_valid[0]),
		.div_s2   (chain_d[0])
	);

	for (genvar gi = 0; gi < NUM_W; gi++) begin : g_cell
		sads_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (chain_valid[gi]),
			.d_in      (chain_d[gi]),
			.valid_out (chain_valid[gi+1]),
			.d_out     (chain_d[gi+1])
		);
	end

	sads_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (chain_valid[NUM_W]),
		.d_in     (chain_d[NUM_W]),
		.done     (done),
		.result   (result)
	);

	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not produce a result");

	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a request");

	a_tag_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.axis_tag == $past(req.axis_index, LATENCY))
		else $error("axis tag mismatch");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NUM_W] |-> chain_d[NUM_W].rem < chain_d[NUM_W].den)
		else $error("divider remainder not below divisor");

endmodule
